// ===== rtl/ipid_pkg.sv =====
// ipid_pkg: widths, command codes, register indexes and fixed-point constants
// for the incremental pid controller; no dependencies, compiled first

package ipid_pkg;

    // field and datapath widths
    localparam int ANGLE_W    = 16;
    localparam int DEG_W      = 24;
    localparam int COEF_W     = 32;
    localparam int LIM_W      = 16;
    localparam int FRAC_W     = 16;
    localparam int DRIVE_W    = LIM_W + FRAC_W;
    localparam int CONV_W     = 40;
    localparam int PROD_W     = COEF_W + DEG_W;
    localparam int PSUM_W     = PROD_W + 2;
    localparam int DU_SHIFT   = 8;
    localparam int DU_W       = PSUM_W - DU_SHIFT;
    localparam int SUM_W      = DU_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // 180/pi in Q7.16, applied to Q3.12 radians, rounded into Q15.8 degrees
    localparam logic signed [22:0] DEG_PER_RAD_Q16 = 23'sd3754936;
    localparam int                 CONV_SHIFT      = 20;
    localparam logic signed [CONV_W-1:0] CONV_ROUND = CONV_W'(64'sd524288);

    // error saturation bounds, signed Q15.8
    localparam logic signed [DEG_W-1:0] ERR_MAX = {1'b0, {(DEG_W-1){1'b1}}};
    localparam logic signed [DEG_W-1:0] ERR_MIN = {1'b1, {(DEG_W-1){1'b0}}};

    // limit reset values, 1/16 us units
    localparam logic [LIM_W-1:0] DRIVE_MIN_RST = 16'd16000;
    localparam logic [LIM_W-1:0] DRIVE_MAX_RST = 16'd32000;

    // item command codes
    typedef enum logic [0:0] {
        CMD_SAMPLE = 1'b0,
        CMD_TICK   = 1'b1
    } cmd_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEF_A    = 3'd0,
        REG_COEF_B    = 3'd1,
        REG_COEF_C    = 3'd2,
        REG_REFERENCE = 3'd3,
        REG_DRIVE_MIN = 3'd4,
        REG_DRIVE_MAX = 3'd5
    } reg_idx_t;

endpackage

// ===== rtl/ipid_meas_if.sv =====
// ipid_meas_if: input channel of the pid controller, one command item per beat
// depends on ipid_pkg

interface ipid_meas_if import ipid_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic [0:0]                command;
    logic signed [ANGLE_W-1:0] angle_q12;

    modport source (output valid, output command, output angle_q12, input ready);
    modport sink   (input valid, input command, input angle_q12, output ready);
endinterface

// ===== rtl/ipid_drive_if.sv =====
// ipid_drive_if: result channel of the pid controller, one drive value per item
// depends on ipid_pkg

interface ipid_drive_if import ipid_pkg::*;;
    logic             valid;
    logic             ready;
    logic [LIM_W-1:0] drive_out;

    modport source (output valid, output drive_out, input ready);
    modport sink   (input valid, input drive_out, output ready);
endinterface

// ===== rtl/incremental_pid_tustin_clamped.sv =====
// incremental_pid_tustin_clamped: velocity-form pid with output clamp, top level
// depends on ipid_pkg, ipid_meas_if, ipid_drive_if

// The block takes one item per clock cycle on meas. A sample item (command 0)
// converts the angle to degrees in the first stage and gives no result. A tick
// item (command 1) that follows at least one sample travels five register
// stages: input, error history, three 32x24 products, product sum, and the
// accumulate-and-clamp stage that loads the drive output register; it reaches
// drive after the error, product and increment registers. Ticks before the
// first sample are dropped in the first stage. Every stage stalls only when
// the one after it is full and held, so meas stays ready while the output
// register is empty or being taken, and a full pipeline still gives one
// result per cycle while drive is ready. Configuration writes on cfg_we take
// effect at the next edge and are meant to happen while no item is in flight.

module incremental_pid_tustin_clamped
    import ipid_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    ipid_meas_if.sink             meas,
    ipid_drive_if.source          drive
);

    // configuration registers
    logic signed [COEF_W-1:0] coef_a_reg;
    logic signed [COEF_W-1:0] coef_b_reg;
    logic signed [COEF_W-1:0] coef_c_reg;
    logic signed [DEG_W-1:0]  reference_reg;
    logic [LIM_W-1:0]         drive_min_reg;
    logic [LIM_W-1:0]         drive_max_reg;

    // controller state
    logic signed [DEG_W-1:0]  angle_deg_reg;
    logic                     angle_valid_reg;
    logic signed [DEG_W-1:0]  err_prev_reg;
    logic signed [DEG_W-1:0]  err_prev2_reg;
    logic [DRIVE_W-1:0]       drive_prev_reg;

    // stage 1: accepted item
    logic                     s1_valid_reg;
    logic [0:0]               s1_cmd_reg;
    logic signed [ANGLE_W-1:0] s1_angle_reg;

    // stage 2: error window
    logic                     s2_valid_reg;
    logic signed [DEG_W-1:0]  s2_e0_reg;
    logic signed [DEG_W-1:0]  s2_e1_reg;
    logic signed [DEG_W-1:0]  s2_e2_reg;

    // stage 3: products
    logic                     s3_valid_reg;
    logic signed [PROD_W-1:0] s3_p0_reg;
    logic signed [PROD_W-1:0] s3_p1_reg;
    logic signed [PROD_W-1:0] s3_p2_reg;

    // stage 4: increment in Q16.16
    logic                     s4_valid_reg;
    logic signed [DU_W-1:0]   s4_du_reg;

    // output register
    logic                     drive_valid_reg;
    logic [LIM_W-1:0]         drive_out_reg;

    // combinational values
    logic                     out_free;
    logic                     s4_free;
    logic                     s3_free;
    logic                     s2_free;
    logic                     s1_free;
    logic                     s1_fire;
    logic                     s1_is_tick;
    logic                     s2_valid_next;
    logic signed [CONV_W-1:0] conv_prod;
    logic signed [CONV_W-1:0] conv_round;
    logic signed [DEG_W-1:0]  angle_deg_next;
    logic signed [DEG_W:0]    err_diff;
    logic signed [DEG_W-1:0]  err_next;
    logic signed [PSUM_W-1:0] prod_sum;
    logic signed [DU_W-1:0]   du_next;
    logic signed [SUM_W-1:0]  acc_sum;
    logic signed [SUM_W-1:0]  lim_hi;
    logic signed [SUM_W-1:0]  lim_lo;
    logic signed [SUM_W-1:0]  acc_clamped;
    logic [DRIVE_W-1:0]       drive_prev_next;

    // stall chain: a stage moves when the next one is empty or moving
    assign out_free = !drive_valid_reg || drive.ready;
    assign s4_free  = !s4_valid_reg || out_free;
    assign s3_free  = !s3_valid_reg || s4_free;
    assign s2_free  = !s2_valid_reg || s3_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign s1_fire  = s1_valid_reg && s2_free;

    assign meas.ready      = s1_free;
    assign drive.valid     = drive_valid_reg;
    assign drive.drive_out = drive_out_reg;

    // degree conversion, rounding halves upward
    always_comb
    begin
        conv_prod      = CONV_W'(s1_angle_reg) * CONV_W'(DEG_PER_RAD_Q16);
        conv_round     = conv_prod + CONV_ROUND;
        angle_deg_next = DEG_W'(conv_round >>> CONV_SHIFT);
    end

    // error against reference, saturated to 24 bits
    always_comb
    begin
        err_diff = (DEG_W+1)'(reference_reg) - (DEG_W+1)'(angle_deg_reg);
        if (err_diff[DEG_W] != err_diff[DEG_W-1])
        begin
            err_next = err_diff[DEG_W] ? ERR_MIN : ERR_MAX;
        end
        else
        begin
            err_next = err_diff[DEG_W-1:0];
        end
    end

    assign s1_is_tick    = (s1_cmd_reg == CMD_TICK);
    assign s2_valid_next = s1_fire && s1_is_tick && angle_valid_reg;

    // increment: floor of the product sum to Q16.16
    always_comb
    begin
        prod_sum = PSUM_W'(s3_p0_reg) + PSUM_W'(s3_p1_reg) + PSUM_W'(s3_p2_reg);
        du_next  = DU_W'(prod_sum >>> DU_SHIFT);
    end

    // accumulate and clamp, max limit tested first
    always_comb
    begin
        acc_sum = SUM_W'($signed({1'b0, drive_prev_reg})) + SUM_W'(s4_du_reg);
        lim_hi  = SUM_W'({drive_max_reg, {FRAC_W{1'b0}}});
        lim_lo  = SUM_W'({drive_min_reg, {FRAC_W{1'b0}}});
        if (acc_sum > lim_hi)
        begin
            acc_clamped = lim_hi;
        end
        else if (acc_sum < lim_lo)
        begin
            acc_clamped = lim_lo;
        end
        else
        begin
            acc_clamped = acc_sum;
        end
        drive_prev_next = acc_clamped[DRIVE_W-1:0];
    end

    // configuration writes; unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_a_reg    <= '0;
            coef_b_reg    <= '0;
            coef_c_reg    <= '0;
            reference_reg <= '0;
            drive_min_reg <= DRIVE_MIN_RST;
            drive_max_reg <= DRIVE_MAX_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_COEF_A:    coef_a_reg    <= cfg_data[COEF_W-1:0];
                REG_COEF_B:    coef_b_reg    <= cfg_data[COEF_W-1:0];
                REG_COEF_C:    coef_c_reg    <= cfg_data[COEF_W-1:0];
                REG_REFERENCE: reference_reg <= cfg_data[DEG_W-1:0];
                REG_DRIVE_MIN: drive_min_reg <= cfg_data[LIM_W-1:0];
                REG_DRIVE_MAX: drive_max_reg <= cfg_data[LIM_W-1:0];
                default:       ;
            endcase
        end
    end

    // pipeline valid bits and controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            s3_valid_reg    <= 1'b0;
            s4_valid_reg    <= 1'b0;
            drive_valid_reg <= 1'b0;
            angle_deg_reg   <= '0;
            angle_valid_reg <= 1'b0;
            err_prev_reg    <= '0;
            err_prev2_reg   <= '0;
            drive_prev_reg  <= '0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= meas.valid;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s2_valid_next;
            end
            if (s3_free)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_free)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (out_free)
            begin
                drive_valid_reg <= s4_valid_reg;
            end

            // sample item updates the stored angle
            if (s1_fire && !s1_is_tick)
            begin
                angle_deg_reg   <= angle_deg_next;
                angle_valid_reg <= 1'b1;
            end

            // tick item shifts the error history
            if (s2_valid_next)
            begin
                err_prev_reg  <= err_next;
                err_prev2_reg <= err_prev_reg;
            end

            // clamped drive is kept as the next starting point
            if (out_free && s4_valid_reg)
            begin
                drive_prev_reg <= drive_prev_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s1_free && meas.valid)
        begin
            s1_cmd_reg   <= meas.command;
            s1_angle_reg <= meas.angle_q12;
        end
        if (s2_valid_next)
        begin
            s2_e0_reg <= err_next;
            s2_e1_reg <= err_prev_reg;
            s2_e2_reg <= err_prev2_reg;
        end
        if (s3_free && s2_valid_reg)
        begin
            s3_p0_reg <= PROD_W'(coef_a_reg) * PROD_W'(s2_e0_reg);
            s3_p1_reg <= PROD_W'(coef_b_reg) * PROD_W'(s2_e1_reg);
            s3_p2_reg <= PROD_W'(coef_c_reg) * PROD_W'(s2_e2_reg);
        end
        if (s4_free && s3_valid_reg)
        begin
            s4_du_reg <= du_next;
        end
        if (out_free && s4_valid_reg)
        begin
            drive_out_reg <= drive_prev_next[DRIVE_W-1:FRAC_W];
        end
    end

endmodule

// ===== rtl/ipid_checker.sv =====
// ipid_checker: port-level assertions for the pid controller, bound to the top
// depends on ipid_pkg and incremental_pid_tustin_clamped

module ipid_checker
    import ipid_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             meas_valid,
    input logic             meas_ready,
    input logic [0:0]       meas_command,
    input logic             drive_valid,
    input logic             drive_ready,
    input logic [LIM_W-1:0] drive_out
);

    logic seen_sample_reg;

    // remember whether any sample item has been accepted
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_sample_reg <= 1'b0;
        end
        else if (meas_valid && meas_ready && (meas_command == CMD_SAMPLE))
        begin
            seen_sample_reg <= 1'b1;
        end
    end

    // no result is shown during reset
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !drive_valid)
        else $error("drive valid during reset");

    // input is never stalled while the output register is free
    a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (!drive_valid || drive_ready) |-> meas_ready)
        else $error("meas stalled with free output");

    // ticks give nothing until a sample has arrived
    a_no_result_before_sample: assert property (@(posedge clk) disable iff (!rst_n)
        !seen_sample_reg |-> !drive_valid)
        else $error("result before any sample");

    // a held result stays put
    a_drive_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (drive_valid && !drive_ready) |=> (drive_valid && $stable(drive_out)))
        else $error("held result changed");

endmodule

bind incremental_pid_tustin_clamped ipid_checker u_ipid_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .meas_valid   (meas.valid),
    .meas_ready   (meas.ready),
    .meas_command (meas.command),
    .drive_valid  (drive.valid),
    .drive_ready  (drive.ready),
    .drive_out    (drive.drive_out)
);

// ===== tb/ipid_drive_checker.sv =====
// ipid_drive_checker: watches the config port and both channels of the pid block,
// predicts every drive item and compares it with what comes out
// depends on ipid_pkg, ipid_meas_if, ipid_drive_if

module ipid_drive_checker
    import ipid_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    ipid_meas_if                  meas,
    ipid_drive_if                 drive,
    output int                    fail_count,
    output int                    pending_count
);

    // 180/pi in Q7.16 and the rounding offset for the >> 20 into Q15.8
    localparam longint DEG_SCALE     = 3754936;
    localparam longint DEG_ROUND     = 524288;
    localparam int     DEG_SHIFT     = 20;
    localparam longint ERR_HI        = 8388607;
    localparam longint ERR_LO        = -8388608;
    localparam int     REPORT_LIMIT  = 10;

    // shadow copy of the configuration registers
    logic signed [COEF_W-1:0] gain_now;
    logic signed [COEF_W-1:0] gain_prev;
    logic signed [COEF_W-1:0] gain_prev2;
    logic signed [DEG_W-1:0]  setpoint;
    logic [LIM_W-1:0]         lim_lo;
    logic [LIM_W-1:0]         lim_hi;

    // controller state
    logic signed [DEG_W-1:0]  angle_deg;
    logic                     have_angle;
    logic signed [DEG_W-1:0]  err_prev;
    logic signed [DEG_W-1:0]  err_prev2;
    logic [DRIVE_W-1:0]       drive_acc;

    logic [LIM_W-1:0]         drive_expected[$];
    logic [LIM_W-1:0]         want;

    // advance the controller by one accepted item, queue the drive it yields
    task automatic predict_item(logic cmd, logic signed [ANGLE_W-1:0] rad);
        longint scaled;
        longint err_now;
        longint incr;
        longint total;
        longint ceiling;
        longint floor_v;
        if (cmd == CMD_SAMPLE) begin
            scaled     = longint'(rad) * DEG_SCALE + DEG_ROUND;
            angle_deg  = DEG_W'(scaled >>> DEG_SHIFT);
            have_angle = 1'b1;
        end
        else if (have_angle) begin
            // saturated error, then the velocity-form increment in Q.24
            err_now = longint'(setpoint) - longint'(angle_deg);
            if (err_now > ERR_HI)
                err_now = ERR_HI;
            else if (err_now < ERR_LO)
                err_now = ERR_LO;
            incr = longint'(gain_now) * err_now
                 + longint'(gain_prev) * longint'(err_prev)
                 + longint'(gain_prev2) * longint'(err_prev2);
            err_prev2 = err_prev;
            err_prev  = DEG_W'(err_now);

            // accumulate in Q16.16 and clamp, upper limit tested first
            total   = longint'(drive_acc) + (incr >>> 8);
            ceiling = longint'(lim_hi) << FRAC_W;
            floor_v = longint'(lim_lo) << FRAC_W;
            if (total > ceiling)
                total = ceiling;
            else if (total < floor_v)
                total = floor_v;
            drive_acc = DRIVE_W'(total);
            drive_expected.push_back(drive_acc[DRIVE_W-1:FRAC_W]);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_now   = '0;
            gain_prev  = '0;
            gain_prev2 = '0;
            setpoint   = '0;
            lim_lo     = DRIVE_MIN_RST;
            lim_hi     = DRIVE_MAX_RST;
            angle_deg  = '0;
            have_angle = 1'b0;
            err_prev   = '0;
            err_prev2  = '0;
            drive_acc  = '0;
            drive_expected.delete();
            fail_count    = 0;
            pending_count = 0;
        end
        else
        begin
            // register writes, unmapped indexes fall through
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_COEF_A:    gain_now   = cfg_data;
                    REG_COEF_B:    gain_prev  = cfg_data;
                    REG_COEF_C:    gain_prev2 = cfg_data;
                    REG_REFERENCE: setpoint   = cfg_data[DEG_W-1:0];
                    REG_DRIVE_MIN: lim_lo     = cfg_data[LIM_W-1:0];
                    REG_DRIVE_MAX: lim_hi     = cfg_data[LIM_W-1:0];
                    default: ;
                endcase
            end

            if (meas.valid && meas.ready)
                predict_item(meas.command, meas.angle_q12);

            // compare each drive item with the oldest prediction
            if (drive.valid && drive.ready)
            begin
                if (drive_expected.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("%0t: drive item %0d arrived with nothing expected",
                                 $time, drive.drive_out);
                end
                else
                begin
                    want = drive_expected.pop_front();
                    if (drive.drive_out !== want)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display("%0t: drive_out mismatch, expected %0d got %0d",
                                     $time, want, drive.drive_out);
                    end
                end
            end

            pending_count = drive_expected.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
// tb_top: stimulus for the incremental pid block: directed corner items, then
// random config phases and command streams with random idling on both channels
// depends on ipid_pkg, ipid_meas_if, ipid_drive_if, the dut and ipid_drive_checker

module tb_top;
    import ipid_pkg::*;

    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int DRAIN_CYCLES    = 12;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 103;
    localparam int BURST_MAX       = 12;

    // indexes the block does not map
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending_count;
    int                    send_idle_pct = 0;
    int                    recv_idle_pct = 0;
    int                    quiet_cycles = 0;

    ipid_meas_if  meas_ch ();
    ipid_drive_if drive_ch ();

    incremental_pid_tustin_clamped dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .meas      (meas_ch),
        .drive     (drive_ch)
    );

    ipid_drive_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .meas          (meas_ch),
        .drive         (drive_ch),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // drive sink: ready drops in random bursts
    initial
    begin : drive_sink
        int stall_left;
        stall_left = 0;
        drive_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left == 0 && $urandom_range(99) < recv_idle_pct)
                stall_left = $urandom_range(BURST_MAX, 1);
            if (stall_left > 0)
            begin
                drive_ch.ready <= 1'b0;
                stall_left--;
            end
            else
                drive_ch.ready <= 1'b1;
        end
    end

    // watchdog on cycles with no handshake and no register write
    always @(posedge clk)
    begin
        if ((meas_ch.valid && meas_ch.ready) || (drive_ch.valid && drive_ch.ready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** incremental_pid_tustin_clamped: FAILED **");
            $finish;
        end
    end

    // one command item, with an optional gap first; returns at the accepting edge
    task automatic send_item(cmd_t cmd, logic [ANGLE_W-1:0] angle);
        int gap;
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            gap = $urandom_range(BURST_MAX, 1);
            meas_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        meas_ch.valid     <= 1'b1;
        meas_ch.command   <= cmd;
        meas_ch.angle_q12 <= angle;
        do
            @(negedge clk);
        while (!meas_ch.ready);
        @(posedge clk);
    endtask

    // stop sending and let the pipeline drain
    task automatic settle();
        meas_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending_count != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    // all six registers, plus now and then a write to an unmapped index
    task automatic apply_settings(logic [COEF_W-1:0] ga, logic [COEF_W-1:0] gb,
                                  logic [COEF_W-1:0] gc, logic [DEG_W-1:0] sp,
                                  logic [LIM_W-1:0] lo, logic [LIM_W-1:0] hi);
        write_reg(REG_COEF_A, ga);
        write_reg(REG_COEF_B, gb);
        write_reg(REG_COEF_C, gc);
        write_reg(REG_REFERENCE, {{(CFG_DATA_W-DEG_W){1'b0}}, sp});
        if ($urandom_range(3) == 0)
            write_reg($urandom_range(1) ? REG_UNMAPPED_HI : REG_UNMAPPED_LO, $urandom());
        write_reg(REG_DRIVE_MIN, {{(CFG_DATA_W-LIM_W){1'b0}}, lo});
        write_reg(REG_DRIVE_MAX, {{(CFG_DATA_W-LIM_W){1'b0}}, hi});
        cfg_we <= 1'b0;
    endtask

    // mostly gains of usable size, some full range, some extremes
    function automatic logic [COEF_W-1:0] pick_gain();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return COEF_W'(int'($urandom_range(524288)) - 262144);
        else if (r < 90)
            return $urandom();
        case ($urandom_range(3))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic logic [DEG_W-1:0] pick_setpoint();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return DEG_W'(int'($urandom_range(262144)) - 131072);
        else if (r < 90)
            return DEG_W'($urandom());
        case ($urandom_range(2))
            0: return 24'h80_0000;
            1: return 24'h7F_FFFF;
            default: return 24'h00_0000;
        endcase
    endfunction

    function automatic logic [ANGLE_W-1:0] pick_angle();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return ANGLE_W'($urandom());
        else if (r < 90)
            return ANGLE_W'(int'($urandom_range(4096)) - 2048);
        case ($urandom_range(3))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            default: return 16'hFFFF;
        endcase
    endfunction

    // ordinary window, inverted window, or limits pinned at the rails
    task automatic pick_limits(output logic [LIM_W-1:0] lo, output logic [LIM_W-1:0] hi);
        int r;
        int base;
        r = $urandom_range(99);
        if (r < 70)
        begin
            base = $urandom_range(30000);
            lo   = LIM_W'(base);
            hi   = LIM_W'(base + $urandom_range(65535 - base));
        end
        else if (r < 85)
        begin
            base = $urandom_range(30000);
            hi   = LIM_W'(base);
            lo   = LIM_W'(base + $urandom_range(65535 - base, 1));
        end
        else
        begin
            lo = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            hi = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        end
    endtask

    initial
    begin : stimulus
        logic [COEF_W-1:0] ga;
        logic [COEF_W-1:0] gb;
        logic [COEF_W-1:0] gc;
        logic [DEG_W-1:0]  sp;
        logic [LIM_W-1:0]  lo;
        logic [LIM_W-1:0]  hi;
        int                mode;

        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= REG_COEF_A;
        cfg_data          <= '0;
        meas_ch.valid     <= 1'b0;
        meas_ch.command   <= CMD_SAMPLE;
        meas_ch.angle_q12 <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: tick before any sample, then reset limits clamp from zero
        send_idle_pct = 15;
        recv_idle_pct = 10;
        send_item(CMD_TICK, 16'($urandom()));
        send_item(CMD_SAMPLE, 16'h0000);
        send_item(CMD_TICK, 16'($urandom()));

        // extreme gains, lowest reference, error saturating low
        settle();
        apply_settings(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 24'h80_0000,
                       16'h0000, 16'hFFFF);
        send_item(CMD_SAMPLE, 16'h7FFF);
        send_item(CMD_TICK, 16'($urandom()));
        send_item(CMD_TICK, 16'($urandom()));
        send_item(CMD_SAMPLE, 16'h8000);
        send_item(CMD_TICK, 16'($urandom()));

        // opposite extremes, highest reference, error saturating high
        settle();
        apply_settings(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 24'h7F_FFFF,
                       16'h0000, 16'hFFFF);
        send_item(CMD_TICK, 16'($urandom()));
        send_item(CMD_TICK, 16'($urandom()));
        send_item(CMD_TICK, 16'($urandom()));

        // inverted limits
        settle();
        apply_settings(32'h0001_0000, 32'hFFFF_8000, 32'h0000_4000, 24'h00_0000,
                       16'd40000, 16'd1000);
        send_item(CMD_SAMPLE, 16'h0001);
        send_item(CMD_TICK, 16'($urandom()));
        send_item(CMD_SAMPLE, 16'hFFFF);
        send_item(CMD_TICK, 16'($urandom()));
        send_item(CMD_TICK, 16'($urandom()));

        // equal limits, then both at zero, then both at full scale
        settle();
        apply_settings(32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 24'h00_0100,
                       16'd20000, 16'd20000);
        send_item(CMD_TICK, 16'($urandom()));
        send_item(CMD_SAMPLE, 16'h1000);
        send_item(CMD_TICK, 16'($urandom()));
        settle();
        apply_settings(32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 24'h00_0100,
                       16'h0000, 16'h0000);
        send_item(CMD_TICK, 16'($urandom()));
        settle();
        apply_settings(32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 24'h00_0100,
                       16'hFFFF, 16'hFFFF);
        send_item(CMD_TICK, 16'($urandom()));

        // random phases, each with its own settings and idling; last ones flat out
        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            ga = pick_gain();
            gb = pick_gain();
            gc = pick_gain();
            sp = pick_setpoint();
            pick_limits(lo, hi);
            apply_settings(ga, gb, gc, sp, lo, hi);
            mode = (p >= PHASES - 2) ? 0 : $urandom_range(2);
            case (mode)
                0:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 15;
                    recv_idle_pct = 10;
                end
                default:
                begin
                    send_idle_pct = 40;
                    recv_idle_pct = 30;
                end
            endcase
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                if ($urandom_range(99) < 35)
                    send_item(CMD_SAMPLE, pick_angle());
                else
                    send_item(CMD_TICK, 16'($urandom()));
            end
        end

        settle();
        if (fail_count == 0 && pending_count == 0)
            $display("** incremental_pid_tustin_clamped: PASSED **");
        else
            $display("** incremental_pid_tustin_clamped: FAILED **");
        $finish;
    end

endmodule
